[rtl/lhf_pkg.sv]
// ----------------------------------------------------------------------------
// lhf_pkg
// Shared types and constants of the line hole filler.
// ----------------------------------------------------------------------------
package lhf_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WID_W       = COL_W + 1;
    localparam int LW_W        = 12;
    localparam int CHAN_W      = 8;

    localparam logic [LW_W-1:0]   WIDTH_RESET = 12'd1920;
    localparam logic [CHAN_W-1:0] AVG_CEILING = 8'd254;

    // configuration port
    localparam int  APB_ADDR_W     = 3;
    localparam int  APB_DATA_W     = 32;
    localparam logic REG_LINE_WIDTH = 1'b0;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [CHAN_W-1:0] y;
        logic [CHAN_W-1:0] u;
        logic [CHAN_W-1:0] v;
    } lhf_pix_t;

    typedef struct packed {
        lhf_pix_t         pix;
        logic [COL_W-1:0] col;
        logic             last;
        logic [WID_W-1:0] width;
    } lhf_entry_t;

endpackage

[rtl/lhf_in_if.sv]
// ----------------------------------------------------------------------------
// lhf_in_if
// Pixel input channel: valid/ready with one YUV pixel and the hole flag.
// ----------------------------------------------------------------------------
interface lhf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_in;
    logic [7:0] cb_in;
    logic [7:0] cr_in;
    logic       common_hole;

    modport source (output valid, output luma_in, output cb_in, output cr_in,
                    output common_hole, input ready);
    modport sink   (input valid, input luma_in, input cb_in, input cr_in,
                    input common_hole, output ready);
endinterface

[rtl/lhf_out_if.sv]
// ----------------------------------------------------------------------------
// lhf_out_if
// Result channel: valid/ready with one filled pixel and the line end flag.
// ----------------------------------------------------------------------------
interface lhf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_out;
    logic [7:0] cb_out;
    logic [7:0] cr_out;
    logic       end_of_line;

    modport source (output valid, output luma_out, output cb_out, output cr_out,
                    output end_of_line, input ready);
    modport sink   (input valid, input luma_out, input cb_out, input cr_out,
                    input end_of_line, output ready);
endinterface

[rtl/line_hole_filler.sv]
// ----------------------------------------------------------------------------
// line_hole_filler
// Horizontal hole filling on a YUV pixel stream, one line at a time.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  pixels    in         valid/ready             luma_in, cb_in, cr_in, common_hole
//  results   out        valid/ready             luma_out, cb_out, cr_out, end_of_line
//  apb       in         psel/penable, pready=1  line_width at address 0
//
//  In the back end a pixel passes a filled-line read, then an output load.
//  After the last column the back end sweeps the line: it reads each column,
//  writes each hole in a fill pass, restarts the read after each run closed
//  before the line end, and adds a read prime and a done state; the filled
//  line has a single write port.
//  The front keeps taking pixels into a 4-entry queue during the sweep.
//  No clearing pass after reset: a fill count makes unwritten columns read zero.
//  A stalled result holds the output register; the queue absorbs the rest.
// ----------------------------------------------------------------------------
module line_hole_filler (
    input  logic                                clk,
    input  logic                                rst_n,
    lhf_in_if.sink                              pixels,
    lhf_out_if.source                           results,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lhf_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lhf_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lhf_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    logic [lhf_pkg::LW_W-1:0] line_width_reg;
    logic [lhf_pkg::LW_W-1:0] line_width_next;
    logic                     reg_hit;

    logic                     q_push;
    lhf_pkg::lhf_entry_t      q_push_entry;
    logic                     q_full;
    logic                     q_pop;
    logic                     q_empty;
    lhf_pkg::lhf_entry_t      q_head;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == lhf_pkg::REG_LINE_WIDTH);
    assign prdata  = reg_hit ? lhf_pkg::APB_DATA_W'(line_width_reg) : '0;

    always_comb
    begin
        line_width_next = line_width_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            line_width_next = pwdata[lhf_pkg::LW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= lhf_pkg::WIDTH_RESET;
        end
        else
        begin
            line_width_reg <= line_width_next;
        end
    end

    lhf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels     (pixels),
        .line_width (line_width_reg),
        .q_full     (q_full),
        .push       (q_push),
        .entry      (q_push_entry)
    );

    lhf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    lhf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .results (results)
    );

endmodule

[rtl/lhf_front.sv]
// ----------------------------------------------------------------------------
// lhf_front
// Accepts pixels, tracks the column, marks holes and queues the work.
// ----------------------------------------------------------------------------
module lhf_front (
    input  logic                      clk,
    input  logic                      rst_n,
    lhf_in_if.sink                    pixels,
    input  logic [lhf_pkg::LW_W-1:0]  line_width,
    input  logic                      q_full,
    output logic                      push,
    output lhf_pkg::lhf_entry_t       entry
);

    localparam int EW_W = (lhf_pkg::LW_W > lhf_pkg::WID_W) ? lhf_pkg::LW_W
                                                            : lhf_pkg::WID_W;

    logic [lhf_pkg::COL_W-1:0] col_cnt_reg;
    logic [lhf_pkg::COL_W-1:0] col_cnt_next;

    logic [EW_W-1:0]           lw_ext;
    logic [EW_W-1:0]           max_ext;
    logic [EW_W-1:0]           ew_clamped;
    logic [lhf_pkg::WID_W-1:0] eff_w;
    logic [lhf_pkg::WID_W-1:0] w_last;
    logic [lhf_pkg::COL_W-1:0] col;
    logic                      last;
    logic                      hole;

    assign lw_ext  = EW_W'(line_width);
    assign max_ext = EW_W'(lhf_pkg::MAX_WIDTH);

    // width zero behaves as one, anything past the line store saturates
    always_comb
    begin
        priority if (lw_ext == '0)
        begin
            ew_clamped = EW_W'(1);
        end
        else if (lw_ext > max_ext)
        begin
            ew_clamped = max_ext;
        end
        else
        begin
            ew_clamped = lw_ext;
        end
    end

    assign eff_w  = ew_clamped[lhf_pkg::WID_W-1:0];
    assign w_last = eff_w - lhf_pkg::WID_W'(1);
    assign col    = ({1'b0, col_cnt_reg} < eff_w) ? col_cnt_reg
                                                  : w_last[lhf_pkg::COL_W-1:0];
    assign last   = ({1'b0, col} == w_last);
    assign hole   = pixels.common_hole || (pixels.luma_in == '0) ||
                    (pixels.cb_in == '0) || (pixels.cr_in == '0);

    assign pixels.ready = !q_full;
    assign push         = pixels.valid && !q_full;

    always_comb
    begin
        entry.pix.y = hole ? '0 : pixels.luma_in;
        entry.pix.u = hole ? '0 : pixels.cb_in;
        entry.pix.v = hole ? '0 : pixels.cr_in;
        entry.col   = col;
        entry.last  = last;
        entry.width = eff_w;
    end

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        if (push)
        begin
            col_cnt_next = last ? '0 : col + lhf_pkg::COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
        end
    end

endmodule

[rtl/lhf_queue.sv]
// ----------------------------------------------------------------------------
// lhf_queue
// Short FIFO of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module lhf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lhf_pkg::lhf_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output lhf_pkg::lhf_entry_t head
);

    lhf_pkg::lhf_entry_t         slot_reg [lhf_pkg::Q_DEPTH];
    logic [lhf_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [lhf_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [lhf_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [lhf_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [lhf_pkg::QPTR_W:0]    count_reg;
    logic [lhf_pkg::QPTR_W:0]    count_next;
    logic                        do_push;
    logic                        do_pop;

    assign full    = (count_reg == (lhf_pkg::QPTR_W+1)'(lhf_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + lhf_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + lhf_pkg::QPTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + (lhf_pkg::QPTR_W+1)'(1);
            2'b01:   count_next = count_reg - (lhf_pkg::QPTR_W+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/lhf_back.sv]
// ----------------------------------------------------------------------------
// lhf_back
// Stores pixels, answers from the filled line and runs the end-of-line fill.
// ----------------------------------------------------------------------------
module lhf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  lhf_pkg::lhf_entry_t q_head,
    output logic                q_pop,
    lhf_out_if.source           results
);

    localparam int COL_W = lhf_pkg::COL_W;
    localparam int WID_W = lhf_pkg::WID_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_BFILL = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    lhf_pkg::lhf_pix_t incoming_mem [lhf_pkg::MAX_WIDTH];
    lhf_pkg::lhf_pix_t filled_mem   [lhf_pkg::MAX_WIDTH];

    logic [2:0]        state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    lhf_pkg::lhf_pix_t out_pix_reg, out_pix_next;
    logic              out_eol_reg, out_eol_next;

    lhf_pkg::lhf_pix_t in_rdata_reg;
    lhf_pkg::lhf_pix_t fl_rdata_reg;
    logic              zero_reg;
    logic              eol_reg;

    logic [WID_W-1:0]  w_reg, w_next;
    logic [WID_W-1:0]  rd_col_reg, rd_col_next;
    logic              ev_valid_reg, ev_valid_next;
    logic [COL_W-1:0]  ev_col_reg, ev_col_next;
    logic              run_reg, run_next;
    logic [COL_W-1:0]  run_start_reg, run_start_next;
    logic              have_l_reg, have_l_next;
    lhf_pkg::lhf_pix_t l_pix_reg, l_pix_next;
    lhf_pkg::lhf_pix_t r_pix_reg, r_pix_next;
    logic              has_r_reg, has_r_next;
    logic [COL_W-1:0]  bf_col_reg, bf_col_next;
    logic [COL_W-1:0]  bf_last_reg, bf_last_next;
    logic              bf_final_reg, bf_final_next;
    logic [WID_W-1:0]  filled_cnt_reg, filled_cnt_next;

    logic              in_rd_en;
    logic [COL_W-1:0]  in_rd_addr;
    logic              fl_wr_en;
    logic [COL_W-1:0]  fl_wr_addr;
    lhf_pkg::lhf_pix_t fl_wr_data;

    logic              ev_hole;
    logic              ev_end;
    logic              leave;
    lhf_pkg::lhf_pix_t avg_pix;

    function automatic logic [lhf_pkg::CHAN_W-1:0] avg_chan(
        input logic [lhf_pkg::CHAN_W-1:0] a,
        input logic [lhf_pkg::CHAN_W-1:0] b
    );
        logic [lhf_pkg::CHAN_W:0]   sum;
        logic [lhf_pkg::CHAN_W-1:0] half;
        sum  = {1'b0, a} + {1'b0, b};
        half = sum[lhf_pkg::CHAN_W:1];
        return (half > lhf_pkg::AVG_CEILING) ? lhf_pkg::AVG_CEILING : half;
    endfunction

    assign avg_pix.y = avg_chan(l_pix_reg.y, r_pix_reg.y);
    assign avg_pix.u = avg_chan(l_pix_reg.u, r_pix_reg.u);
    assign avg_pix.v = avg_chan(l_pix_reg.v, r_pix_reg.v);

    // stored pixels are all-zero or all-nonzero, so luma alone tells a hole
    assign ev_hole = (in_rdata_reg.y == '0);
    assign ev_end  = ({1'b0, ev_col_reg} == (w_reg - WID_W'(1)));

    assign q_pop = (state_reg == ST_IDLE) && !q_empty &&
                   (!out_valid_reg || results.ready);

    assign results.valid       = out_valid_reg;
    assign results.luma_out    = out_pix_reg.y;
    assign results.cb_out      = out_pix_reg.u;
    assign results.cr_out      = out_pix_reg.v;
    assign results.end_of_line = out_eol_reg;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        out_pix_next    = out_pix_reg;
        out_eol_next    = out_eol_reg;
        w_next          = w_reg;
        rd_col_next     = rd_col_reg;
        ev_valid_next   = ev_valid_reg;
        ev_col_next     = ev_col_reg;
        run_next        = run_reg;
        run_start_next  = run_start_reg;
        have_l_next     = have_l_reg;
        l_pix_next      = l_pix_reg;
        r_pix_next      = r_pix_reg;
        has_r_next      = has_r_reg;
        bf_col_next     = bf_col_reg;
        bf_last_next    = bf_last_reg;
        bf_final_next   = bf_final_reg;
        filled_cnt_next = filled_cnt_reg;
        in_rd_en        = 1'b0;
        in_rd_addr      = rd_col_reg[COL_W-1:0];
        fl_wr_en        = 1'b0;
        fl_wr_addr      = ev_col_reg;
        fl_wr_data      = in_rdata_reg;
        leave           = 1'b0;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    state_next = ST_LOAD;
                    if (q_head.last)
                    begin
                        w_next = q_head.width;
                    end
                end
            end

            ST_LOAD:
            begin
                out_valid_next = 1'b1;
                out_pix_next   = zero_reg ? '0 : fl_rdata_reg;
                out_eol_next   = eol_reg;
                if (eol_reg)
                begin
                    state_next    = ST_SCAN;
                    rd_col_next   = '0;
                    ev_valid_next = 1'b0;
                    run_next      = 1'b0;
                    have_l_next   = 1'b0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (ev_valid_reg)
                begin
                    if (!ev_hole)
                    begin
                        fl_wr_en = 1'b1;
                        if (run_reg)
                        begin
                            // a hole run closed by a valid pixel on its right
                            leave         = 1'b1;
                            state_next    = ST_BFILL;
                            run_next      = 1'b0;
                            bf_col_next   = run_start_reg;
                            bf_last_next  = ev_col_reg - COL_W'(1);
                            r_pix_next    = in_rdata_reg;
                            has_r_next    = 1'b1;
                            bf_final_next = ev_end;
                        end
                        else
                        begin
                            l_pix_next  = in_rdata_reg;
                            have_l_next = 1'b1;
                            if (ev_end)
                            begin
                                leave      = 1'b1;
                                state_next = ST_DONE;
                            end
                        end
                    end
                    else
                    begin
                        if (!run_reg)
                        begin
                            run_next       = 1'b1;
                            run_start_next = ev_col_reg;
                        end
                        if (ev_end)
                        begin
                            // trailing run, no right neighbour
                            leave         = 1'b1;
                            state_next    = ST_BFILL;
                            run_next      = 1'b0;
                            bf_col_next   = run_reg ? run_start_reg : ev_col_reg;
                            bf_last_next  = ev_col_reg;
                            has_r_next    = 1'b0;
                            bf_final_next = 1'b1;
                        end
                    end
                end

                if (!leave && (rd_col_reg < w_reg))
                begin
                    in_rd_en      = 1'b1;
                    rd_col_next   = rd_col_reg + WID_W'(1);
                    ev_valid_next = 1'b1;
                    ev_col_next   = rd_col_reg[COL_W-1:0];
                end
                else
                begin
                    ev_valid_next = 1'b0;
                end
            end

            ST_BFILL:
            begin
                fl_wr_en   = 1'b1;
                fl_wr_addr = bf_col_reg;
                priority if (have_l_reg && has_r_reg && (bf_col_reg == bf_last_reg))
                begin
                    fl_wr_data = avg_pix;
                end
                else if (have_l_reg)
                begin
                    fl_wr_data = l_pix_reg;
                end
                else if (has_r_reg)
                begin
                    fl_wr_data = r_pix_reg;
                end
                else
                begin
                    fl_wr_data = '0;
                end

                if (bf_col_reg == bf_last_reg)
                begin
                    if (has_r_reg)
                    begin
                        l_pix_next  = r_pix_reg;
                        have_l_next = 1'b1;
                    end
                    state_next = bf_final_reg ? ST_DONE : ST_SCAN;
                end
                else
                begin
                    bf_col_next = bf_col_reg + COL_W'(1);
                end
            end

            ST_DONE:
            begin
                if (w_reg > filled_cnt_reg)
                begin
                    filled_cnt_next = w_reg;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            rd_col_reg     <= '0;
            ev_valid_reg   <= 1'b0;
            run_reg        <= 1'b0;
            have_l_reg     <= 1'b0;
            has_r_reg      <= 1'b0;
            bf_final_reg   <= 1'b0;
            filled_cnt_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            rd_col_reg     <= rd_col_next;
            ev_valid_reg   <= ev_valid_next;
            run_reg        <= run_next;
            have_l_reg     <= have_l_next;
            has_r_reg      <= has_r_next;
            bf_final_reg   <= bf_final_next;
            filled_cnt_reg <= filled_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pix_reg   <= out_pix_next;
        out_eol_reg   <= out_eol_next;
        w_reg         <= w_next;
        ev_col_reg    <= ev_col_next;
        run_start_reg <= run_start_next;
        l_pix_reg     <= l_pix_next;
        r_pix_reg     <= r_pix_next;
        bf_col_reg    <= bf_col_next;
        bf_last_reg   <= bf_last_next;
        if (q_pop)
        begin
            eol_reg  <= q_head.last;
            // columns past the widest line ever copied still read as zero
            zero_reg <= ({1'b0, q_head.col} >= filled_cnt_reg);
        end
    end

    // line being collected
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            incoming_mem[q_head.col] <= q_head.pix;
        end
        if (in_rd_en)
        begin
            in_rdata_reg <= incoming_mem[in_rd_addr];
        end
    end

    // last filled line
    always_ff @(posedge clk)
    begin
        if (fl_wr_en)
        begin
            filled_mem[fl_wr_addr] <= fl_wr_data;
        end
        if (q_pop)
        begin
            fl_rdata_reg <= filled_mem[q_head.col];
        end
    end

endmodule

[tb/line_hole_filler_tb.sv]
// ----------------------------------------------------------------------------
// line_hole_filler_tb
// Self-checking bench for the line hole filler.
// Pixels are driven through the valid/ready channel with random gaps on both
// sides. A behavioural line buffer in the bench fills each line as the block
// should, and every result transaction is compared field by field with the
// oldest filled pixel due. A short directed table comes first (start-up
// zeros, saturated averages, multi-pass fills, all-hole lines, widths 0 and 1,
// width cut mid-line). Random phases follow at mixed widths and hole
// densities, including one phase at a width past the line store.
// ----------------------------------------------------------------------------
module line_hole_filler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lhf_pkg::*;

    localparam int unsigned SMALL_PIXELS = 1325;
    localparam int unsigned BIG_PHASE_AT = 600;
    localparam int unsigned WIDE_PIXELS  = 240;
    localparam logic [APB_ADDR_W-1:0] LINE_WIDTH_ADDR = APB_ADDR_W'(REG_LINE_WIDTH) << 2;
    localparam lhf_pix_t BLACK = '0;

    typedef struct packed {
        lhf_pix_t pix;
        logic     common_hole;
    } pixel_req_t;

    typedef struct packed {
        lhf_pix_t pix;
        logic     eol;
    } filled_px_t;

    typedef struct packed {
        logic [LW_W-1:0] width;
        lhf_pix_t        pix;
        logic            hole;
        logic            typed;
        lhf_pix_t        exp_pix;
        logic            exp_eol;
    } stim_row_t;

    // width, pixel, forced hole, typed expectation, expected pixel, expected eol
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        // first line after reset reads zeros
        '{12'd4, '{8'd255, 8'd255, 8'd255}, 1'b0, 1'b1, BLACK, 1'b0},
        '{12'd4, '{8'd0,   8'd10,  8'd10},  1'b0, 1'b1, BLACK, 1'b0},
        '{12'd4, '{8'd1,   8'd1,   8'd1},   1'b0, 1'b1, BLACK, 1'b0},
        '{12'd4, '{8'd10,  8'd20,  8'd30},  1'b1, 1'b1, BLACK, 1'b1},
        // saturated neighbours: average clamps
        '{12'd4, '{8'd255, 8'd255, 8'd255}, 1'b0, 1'b0, BLACK, 1'b0},
        '{12'd4, '{8'd128, 8'd0,   8'd5},   1'b0, 1'b0, BLACK, 1'b0},
        '{12'd4, '{8'd255, 8'd255, 8'd255}, 1'b0, 1'b0, BLACK, 1'b0},
        '{12'd4, '{8'd255, 8'd1,   8'd255}, 1'b0, 1'b0, BLACK, 1'b0},
        // one-sided copies, first column only filled on a second pass
        '{12'd6, '{8'd0,   8'd0,   8'd0},   1'b0, 1'b0, BLACK, 1'b0},
        '{12'd6, '{8'd9,   8'd0,   8'd9},   1'b0, 1'b0, BLACK, 1'b0},
        '{12'd6, '{8'd50,  8'd60,  8'd70},  1'b0, 1'b0, BLACK, 1'b0},
        '{12'd6, '{8'd3,   8'd3,   8'd3},   1'b1, 1'b0, BLACK, 1'b0},
        '{12'd6, '{8'd77,  8'd0,   8'd0},   1'b0, 1'b0, BLACK, 1'b0},
        '{12'd6, '{8'd0,   8'd255, 8'd255}, 1'b0, 1'b0, BLACK, 1'b0},
        // all-hole line stays zero
        '{12'd3, '{8'd0,   8'd0,   8'd0},   1'b0, 1'b0, BLACK, 1'b0},
        '{12'd3, '{8'd255, 8'd255, 8'd255}, 1'b1, 1'b0, BLACK, 1'b0},
        '{12'd3, '{8'd5,   8'd5,   8'd0},   1'b0, 1'b0, BLACK, 1'b0},
        // width one, then zero (behaves as one)
        '{12'd1, '{8'd0,   8'd200, 8'd200}, 1'b0, 1'b0, BLACK, 1'b0},
        '{12'd0, '{8'd200, 8'd100, 8'd50},  1'b0, 1'b0, BLACK, 1'b0},
        // width cut to 2 after three columns: column saturates, line ends
        '{12'd5, '{8'd1,   8'd2,   8'd3},   1'b0, 1'b0, BLACK, 1'b0},
        '{12'd5, '{8'd4,   8'd5,   8'd6},   1'b0, 1'b0, BLACK, 1'b0},
        '{12'd5, '{8'd7,   8'd8,   8'd9},   1'b0, 1'b0, BLACK, 1'b0},
        '{12'd2, '{8'd0,   8'd0,   8'd0},   1'b1, 1'b0, BLACK, 1'b0},
        '{12'd2, '{8'd255, 8'd128, 8'd1},   1'b0, 1'b0, BLACK, 1'b0},
        '{12'd2, '{8'd0,   8'd1,   8'd1},   1'b0, 1'b0, BLACK, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    lhf_in_if  pix_if ();
    lhf_out_if res_if ();

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    line_hole_filler uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_if),
        .results (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // line buffer model
    lhf_pix_t        gather_line [MAX_WIDTH];
    lhf_pix_t        prev_line   [MAX_WIDTH];
    int unsigned     col_pos;
    logic [LW_W-1:0] width_reg;

    filled_px_t  filled_due [$];
    int unsigned mismatches;
    int unsigned pixels_sent;
    int unsigned lines_done;
    int unsigned width_writes;

    int unsigned sink_hold;
    bit          sink_calm;

    function automatic int unsigned active_width();
        int unsigned w;
        w = 32'(width_reg);
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic bit solid(lhf_pix_t p);
        return p.y != 0 && p.u != 0 && p.v != 0;
    endfunction

    function automatic logic [CHAN_W-1:0] mean_clamped(logic [CHAN_W-1:0] a,
                                                        logic [CHAN_W-1:0] b);
        logic [CHAN_W:0] s;
        s = ({1'b0, a} + {1'b0, b}) >> 1;
        return (s > AVG_CEILING) ? AVG_CEILING : s[CHAN_W-1:0];
    endfunction

    // in-place left-to-right passes until one fills nothing
    function automatic void fill_holes(int w);
        bit       changed;
        lhf_pix_t l;
        lhf_pix_t r;
        changed = 1'b1;
        while (changed) begin
            changed = 1'b0;
            for (int i = 0; i < w; i++) begin
                if (gather_line[i].y != 0) continue;
                if (i == 0) begin
                    if (w > 1 && solid(gather_line[1])) begin
                        gather_line[0] = gather_line[1];
                        changed = 1'b1;
                    end
                end
                else if (i == w - 1) begin
                    if (solid(gather_line[i-1])) begin
                        gather_line[i] = gather_line[i-1];
                        changed = 1'b1;
                    end
                end
                else begin
                    l = gather_line[i-1];
                    r = gather_line[i+1];
                    // interior neighbours judged on luma only
                    if (l.y != 0 && r.y != 0) begin
                        gather_line[i].y = mean_clamped(l.y, r.y);
                        gather_line[i].u = mean_clamped(l.u, r.u);
                        gather_line[i].v = mean_clamped(l.v, r.v);
                        changed = 1'b1;
                    end
                    else if (l.y != 0) begin
                        gather_line[i] = l;
                        changed = 1'b1;
                    end
                    else if (r.y != 0) begin
                        gather_line[i] = r;
                        changed = 1'b1;
                    end
                end
            end
        end
    endfunction

    function automatic filled_px_t next_filled_pixel(pixel_req_t req);
        int unsigned w;
        int unsigned col;
        bit          is_hole;
        filled_px_t  res;
        w = active_width();
        col = (col_pos < w) ? col_pos : w - 1;
        is_hole = req.common_hole || req.pix.y == 0 || req.pix.u == 0 || req.pix.v == 0;
        res.pix = prev_line[col];
        res.eol = (col == w - 1);
        gather_line[col] = is_hole ? BLACK : req.pix;
        if (res.eol) begin
            fill_holes(w);
            for (int i = 0; i < w; i++) prev_line[i] = gather_line[i];
            col_pos = 0;
            lines_done++;
        end
        else begin
            col_pos = col + 1;
        end
        return res;
    endfunction

    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CHAN_W-1:0] bright_chan();
        if ($urandom_range(0, 4) == 0) return CHAN_W'($urandom_range(240, 255));
        return CHAN_W'($urandom_range(1, 255));
    endfunction

    function automatic pixel_req_t random_pixel(int unsigned hole_pct);
        pixel_req_t req;
        req.pix.y = bright_chan();
        req.pix.u = bright_chan();
        req.pix.v = bright_chan();
        req.common_hole = 1'b0;
        if ($urandom_range(0, 99) < hole_pct) begin
            case ($urandom_range(0, 3))
                0: begin
                    req.common_hole = 1'b1;
                    req.pix = 24'($urandom);
                end
                1: req.pix.y = '0;
                2: req.pix.u = '0;
                default: req.pix.v = '0;
            endcase
        end
        return req;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %0h, got %0h at %0t", what, exp_v, act_v, $time);
    endtask

    // all bus tasks start and end on a falling edge
    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apb_read(logic [APB_ADDR_W-1:0] addr, output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // settle: also sit out a worst-case line sweep
    task automatic drain_results(bit settle);
        pix_if.valid <= 1'b0;
        do @(negedge clk); while (filled_due.size() != 0);
        if (settle) repeat (3 * active_width() + 50) @(negedge clk);
    endtask

    task automatic set_width(logic [LW_W-1:0] w);
        logic [APB_DATA_W-1:0] wdata;
        logic [APB_DATA_W-1:0] readback;
        drain_results(1'b1);
        wdata = $urandom;
        wdata[LW_W-1:0] = w;
        apb_write(LINE_WIDTH_ADDR, wdata);
        width_reg = w;
        width_writes++;
        apb_read(LINE_WIDTH_ADDR, readback);
        if (readback !== APB_DATA_W'(w))
            note_mismatch("line_width readback", 32'(w), readback);
    endtask

    task automatic send_pixel(pixel_req_t req, bit calm, bit typed, filled_px_t typed_res);
        int unsigned gap;
        filled_px_t  predicted;
        gap = calm ? 0 : idle_span();
        if (gap != 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.luma_in     <= req.pix.y;
        pix_if.cb_in       <= req.pix.u;
        pix_if.cr_in       <= req.pix.v;
        pix_if.common_hole <= req.common_hole;
        @(posedge clk);
        while (pix_if.ready !== 1'b1) @(posedge clk);
        predicted = next_filled_pixel(req);
        filled_due.push_back(typed ? typed_res : predicted);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic run_phase(logic [LW_W-1:0] w, int unsigned count, int unsigned hole_pct);
        bit calm;
        calm = ($urandom_range(0, 3) == 0);
        set_width(w);
        repeat (count) begin
            if ($urandom_range(0, 299) == 0) drain_results(1'b0);
            send_pixel(random_pixel(hole_pct), calm, 1'b0, '0);
        end
    endtask

    always @(negedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end
        else if (sink_hold != 0) begin
            res_if.ready <= 1'b0;
            sink_hold--;
        end
        else begin
            res_if.ready <= 1'b1;
            sink_hold = sink_calm ? 0 : idle_span();
        end
        if ($urandom_range(0, 149) == 0) sink_calm = !sink_calm;
    end

    always @(posedge clk) begin
        filled_px_t want;
        if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (filled_due.size() == 0) begin
                note_mismatch("result transaction with none pending", 0, 1);
            end
            else begin
                want = filled_due.pop_front();
                if (res_if.luma_out !== want.pix.y)
                    note_mismatch("luma_out", 32'(want.pix.y), 32'(res_if.luma_out));
                if (res_if.cb_out !== want.pix.u)
                    note_mismatch("cb_out", 32'(want.pix.u), 32'(res_if.cb_out));
                if (res_if.cr_out !== want.pix.v)
                    note_mismatch("cr_out", 32'(want.pix.v), 32'(res_if.cr_out));
                if (res_if.end_of_line !== want.eol)
                    note_mismatch("end_of_line", 32'(want.eol), 32'(res_if.end_of_line));
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [APB_DATA_W-1:0] readback;
        stim_row_t             row;
        pixel_req_t            req;
        filled_px_t            typed_res;
        int unsigned           w;
        int unsigned           eff;
        int unsigned           count;
        int unsigned           hole_pct;
        int unsigned           small_sent;
        bit                    big_done;

        pix_if.valid       = 1'b0;
        pix_if.luma_in     = '0;
        pix_if.cb_in       = '0;
        pix_if.cr_in       = '0;
        pix_if.common_hole = 1'b0;
        res_if.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        sink_hold          = 0;
        sink_calm          = 1'b0;
        mismatches         = 0;
        pixels_sent        = 0;
        lines_done         = 0;
        width_writes       = 0;
        col_pos            = 0;
        width_reg          = WIDTH_RESET;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            gather_line[i] = BLACK;
            prev_line[i]   = BLACK;
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        apb_read(LINE_WIDTH_ADDR, readback);
        if (readback !== APB_DATA_W'(WIDTH_RESET))
            note_mismatch("line_width after reset", 32'(WIDTH_RESET), readback);

        for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
            row = DIRECTED_ROWS[i];
            if (row.width != width_reg) set_width(row.width);
            req.pix = row.pix;
            req.common_hole = row.hole;
            typed_res.pix = row.exp_pix;
            typed_res.eol = row.exp_eol;
            send_pixel(req, 1'b0, row.typed, typed_res);
        end

        small_sent = 0;
        big_done = 1'b0;
        while (small_sent < SMALL_PIXELS) begin
            if (!big_done && small_sent >= BIG_PHASE_AT) begin
                // width past the line store: columns run on beyond every earlier line
                count = SMALL_PIXELS - small_sent;
                if (count > WIDE_PIXELS) count = WIDE_PIXELS;
                run_phase(12'hFFF, count, 30);
                small_sent += count;
                big_done = 1'b1;
            end
            case ($urandom_range(0, 19))
                0:       w = 0;
                1:       w = 1;
                2:       w = 2;
                3, 4, 5: w = $urandom_range(13, 64);
                6:       w = $urandom_range(65, 300);
                default: w = $urandom_range(3, 12);
            endcase
            eff = (w == 0) ? 1 : w;
            count = eff * ((w > 64) ? $urandom_range(1, 2) : $urandom_range(1, 4));
            // leave some phases mid-line so the next width may cut the line short
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, eff);
            if (small_sent + count > SMALL_PIXELS) count = SMALL_PIXELS - small_sent;
            case ($urandom_range(0, 4))
                0:       hole_pct = 0;
                1:       hole_pct = 15;
                2:       hole_pct = 40;
                3:       hole_pct = 75;
                default: hole_pct = 100;
            endcase
            run_phase(LW_W'(w), count, hole_pct);
            small_sent += count;
        end

        drain_results(1'b1);

        $display("Covered %0d pixels and %0d filled lines over %0d width writes",
                 pixels_sent, lines_done, width_writes);
        $display("(widths 0, 1, 2..300 and 4095); mismatches in results and reads: %0d",
                 mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
